/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Whenever cond holds, the property (may start with a delay) must follow.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`endif

/* sv/rgsm_pkg.sv */
`default_nettype none

package rgsm_pkg;

  localparam int SLOT_W = 10;
  localparam int SLOTS = 1024;

  // Register stages inside one gain lane, input to contribution.
  localparam int LANE_STAGES = 7;

  localparam logic [6:0] RAMP_MAX = 7'd64;

  localparam logic OP_MIX = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic FMT_U8 = 1'b0;
  localparam logic FMT_S16 = 1'b1;

  localparam logic [1:0] MODE_MONO = 2'd0;
  localparam logic [1:0] MODE_STEREO = 2'd1;

  localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd0;
  localparam logic [2:0] REG_CHANNEL_MODE = 3'd1;
  localparam logic [2:0] REG_CUR_LEFT = 3'd2;
  localparam logic [2:0] REG_CUR_RIGHT = 3'd3;
  localparam logic [2:0] REG_TGT_LEFT = 3'd4;
  localparam logic [2:0] REG_TGT_RIGHT = 3'd5;
  localparam logic [2:0] REG_RAMP_LENGTH = 3'd6;
  localparam logic [2:0] REG_OUTPUT_MONO = 3'd7;

  // floor(2^28 / r) for r = 1..64, entry r-1
  localparam logic [28:0] RECIP_ONE = 29'h1000_0000;
  localparam logic [28:0] RECIP_TABLE [64] = '{
    RECIP_ONE / 29'd1,  RECIP_ONE / 29'd2,  RECIP_ONE / 29'd3,  RECIP_ONE / 29'd4,
    RECIP_ONE / 29'd5,  RECIP_ONE / 29'd6,  RECIP_ONE / 29'd7,  RECIP_ONE / 29'd8,
    RECIP_ONE / 29'd9,  RECIP_ONE / 29'd10, RECIP_ONE / 29'd11, RECIP_ONE / 29'd12,
    RECIP_ONE / 29'd13, RECIP_ONE / 29'd14, RECIP_ONE / 29'd15, RECIP_ONE / 29'd16,
    RECIP_ONE / 29'd17, RECIP_ONE / 29'd18, RECIP_ONE / 29'd19, RECIP_ONE / 29'd20,
    RECIP_ONE / 29'd21, RECIP_ONE / 29'd22, RECIP_ONE / 29'd23, RECIP_ONE / 29'd24,
    RECIP_ONE / 29'd25, RECIP_ONE / 29'd26, RECIP_ONE / 29'd27, RECIP_ONE / 29'd28,
    RECIP_ONE / 29'd29, RECIP_ONE / 29'd30, RECIP_ONE / 29'd31, RECIP_ONE / 29'd32,
    RECIP_ONE / 29'd33, RECIP_ONE / 29'd34, RECIP_ONE / 29'd35, RECIP_ONE / 29'd36,
    RECIP_ONE / 29'd37, RECIP_ONE / 29'd38, RECIP_ONE / 29'd39, RECIP_ONE / 29'd40,
    RECIP_ONE / 29'd41, RECIP_ONE / 29'd42, RECIP_ONE / 29'd43, RECIP_ONE / 29'd44,
    RECIP_ONE / 29'd45, RECIP_ONE / 29'd46, RECIP_ONE / 29'd47, RECIP_ONE / 29'd48,
    RECIP_ONE / 29'd49, RECIP_ONE / 29'd50, RECIP_ONE / 29'd51, RECIP_ONE / 29'd52,
    RECIP_ONE / 29'd53, RECIP_ONE / 29'd54, RECIP_ONE / 29'd55, RECIP_ONE / 29'd56,
    RECIP_ONE / 29'd57, RECIP_ONE / 29'd58, RECIP_ONE / 29'd59, RECIP_ONE / 29'd60,
    RECIP_ONE / 29'd61, RECIP_ONE / 29'd62, RECIP_ONE / 29'd63, RECIP_ONE / 29'd64
  };

  typedef struct packed {
    logic               operation;
    logic [SLOT_W-1:0]  buffer_slot;
    logic [15:0]        run_position;
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
  } mix_in_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } mix_out_t;

  typedef struct packed {
    logic signed [16:0] sample;
    logic [15:0]        cur_volume;
    logic [15:0]        tgt_volume;
    logic [15:0]        position;
    logic [6:0]         ramp_len;
    logic               spatial;
  } lane_in_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [SLOT_W-1:0] slot;
  } acc_ctl_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [63:0]       data;
  } ram_wr_t;

endpackage

`default_nettype wire

/* sv/rgsm_ram.sv */
`default_nettype none

module rgsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the word stored before a same-cycle write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/rgsm_lane.sv */
`default_nettype none

module rgsm_lane (
  input  logic               clk,
  input  rgsm_pkg::lane_in_t lane_in,
  output logic [31:0]        contrib
);

  import rgsm_pkg::*;

  logic [6:0]  step;
  logic [6:0]  rest;
  logic        in_ramp;
  logic [22:0] cur_term;
  logic [22:0] tgt_term;

  // stage a
  logic signed [16:0] a_sample;
  logic [15:0]        a_tgt;
  logic               a_ramp;
  logic               a_spatial;
  logic [6:0]         a_len;
  logic [22:0]        a_cur_term;
  logic [22:0]        a_tgt_term;
  logic [22:0]        a_sum;

  // stage b
  logic signed [16:0] b_sample;
  logic [15:0]        b_tgt;
  logic               b_ramp;
  logic               b_spatial;
  logic [6:0]         b_len;
  logic [21:0]        b_x;
  logic [5:0]         b_idx;
  logic [50:0]        b_prod;

  // stage c
  logic signed [16:0] c_sample;
  logic [15:0]        c_tgt;
  logic               c_ramp;
  logic               c_spatial;
  logic [6:0]         c_len;
  logic [21:0]        c_x;
  logic [15:0]        c_q;

  // stage d
  logic signed [16:0] d_sample;
  logic [15:0]        d_tgt;
  logic               d_ramp;
  logic               d_spatial;
  logic [6:0]         d_len;
  logic [21:0]        d_x;
  logic [15:0]        d_q;
  logic [22:0]        d_qr;
  logic [22:0]        d_rem;

  // stage e
  logic signed [16:0] e_sample;
  logic [15:0]        e_tgt;
  logic               e_ramp;
  logic               e_spatial;
  logic [15:0]        e_gain;
  logic [15:0]        e_mul;

  // stage f
  logic               f_ramp;
  logic signed [33:0] f_prod;
  logic signed [33:0] f_round;
  logic signed [33:0] f_shift;

  assign step     = {1'b0, lane_in.position[5:0]} + 7'd1;
  assign rest     = lane_in.ramp_len - step;
  assign in_ramp  = lane_in.position < {9'd0, lane_in.ramp_len};
  assign cur_term = {7'd0, lane_in.cur_volume} * {16'd0, rest};
  assign tgt_term = {7'd0, lane_in.tgt_volume} * {16'd0, step};

  always_ff @(posedge clk) begin
    a_sample   <= lane_in.sample;
    a_tgt      <= lane_in.tgt_volume;
    a_ramp     <= in_ramp;
    a_spatial  <= lane_in.spatial;
    a_len      <= lane_in.ramp_len;
    a_cur_term <= cur_term;
    a_tgt_term <= tgt_term;
  end

  // spatialized gain divides by 2R: halve first, then divide by R
  assign a_sum = a_cur_term + a_tgt_term;

  always_ff @(posedge clk) begin
    b_sample  <= a_sample;
    b_tgt     <= a_tgt;
    b_ramp    <= a_ramp;
    b_spatial <= a_spatial;
    b_len     <= a_len;
    b_x       <= a_spatial ? a_sum[22:1] : a_sum[21:0];
  end

  // quotient estimate from reciprocal, low by at most one
  assign b_idx  = b_len[5:0] - 6'd1;
  assign b_prod = {29'd0, b_x} * {22'd0, RECIP_TABLE[b_idx]};

  always_ff @(posedge clk) begin
    c_sample  <= b_sample;
    c_tgt     <= b_tgt;
    c_ramp    <= b_ramp;
    c_spatial <= b_spatial;
    c_len     <= b_len;
    c_x       <= b_x;
    c_q       <= b_prod[43:28];
  end

  always_ff @(posedge clk) begin
    d_sample  <= c_sample;
    d_tgt     <= c_tgt;
    d_ramp    <= c_ramp;
    d_spatial <= c_spatial;
    d_len     <= c_len;
    d_x       <= c_x;
    d_q       <= c_q;
    d_qr      <= {7'd0, c_q} * {16'd0, c_len};
  end

  // bump the estimate when the remainder still holds one divisor
  assign d_rem = {1'b0, d_x} - d_qr;

  always_ff @(posedge clk) begin
    e_sample  <= d_sample;
    e_tgt     <= d_tgt;
    e_ramp    <= d_ramp;
    e_spatial <= d_spatial;
    e_gain    <= d_q + ((d_rem >= {16'd0, d_len}) ? 16'd1 : 16'd0);
  end

  // one multiplier serves both the ramp gain and the integer gain
  assign e_mul = e_ramp ? e_gain :
                 (e_spatial ? {9'd0, e_tgt[15:9]} : {8'd0, e_tgt[15:8]});

  always_ff @(posedge clk) begin
    f_ramp <= e_ramp;
    f_prod <= 34'(e_sample) * $signed({18'd0, e_mul});
  end

  // ramp products drop 8 fraction bits, rounding toward zero
  assign f_round = f_prod + (f_prod[33] ? 34'sd255 : 34'sd0);
  assign f_shift = f_round >>> 8;

  always_ff @(posedge clk) begin
    contrib <= f_ramp ? f_shift[31:0] : f_prod[31:0];
  end

endmodule

`default_nettype wire

/* sv/rgsm_merge.sv */
`default_nettype none

module rgsm_merge (
  input  logic               clk,
  input  logic               rst,
  input  rgsm_pkg::acc_ctl_t ctl,
  input  logic [31:0]        contrib_left,
  input  logic [31:0]        contrib_right,
  input  logic [63:0]        rd_data,
  input  logic               output_mono,
  output rgsm_pkg::ram_wr_t  wr,
  output logic               res_valid,
  output rgsm_pkg::mix_out_t res
);

  import rgsm_pkg::*;

  localparam logic signed [23:0] SAT_HI = 24'sd32767;
  localparam logic signed [23:0] SAT_LO = -24'sd32768;

  logic              fwd_valid;
  logic [SLOT_W-1:0] fwd_slot;
  logic [63:0]       fwd_data;
  logic [63:0]       old_word;
  logic [63:0]       new_word;

  function automatic logic signed [15:0] drain_channel(input logic [31:0] acc);
    logic signed [31:0] v;
    logic signed [31:0] adj;
    logic signed [23:0] q;
    v   = $signed(acc);
    adj = v + (v[31] ? 32'sd255 : 32'sd0);
    q   = 24'(adj >>> 8);
    if (q > SAT_HI) begin
      return 16'sh7FFF;
    end else if (q < SAT_LO) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  // the RAM still holds the old value for a slot written in the previous cycle
  assign old_word = (fwd_valid && (fwd_slot == ctl.slot)) ? fwd_data : rd_data;
  assign new_word = (ctl.op == OP_MIX) ?
                    {old_word[63:32] + contrib_right, old_word[31:0] + contrib_left} :
                    64'd0;

  always_comb begin
    wr.en         = ctl.valid;
    wr.addr       = ctl.slot;
    wr.data       = new_word;
    res_valid     = ctl.valid && (ctl.op == OP_DRAIN);
    res.out_left  = drain_channel(old_word[31:0]);
    res.out_right = output_mono ? 16'sd0 : drain_channel(old_word[63:32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    fwd_slot <= ctl.slot;
    fwd_data <= new_word;
  end

endmodule

`default_nettype wire

/* sv/ramped_gain_sample_mixer.sv */
// Ramped-gain sample mixer: adds one track frame into a 1024-slot stereo
// accumulation memory, or drains a slot to a saturated 16-bit pair.
// Channels: in (valid/ready, one mix or drain word), out (valid/ready, one
// word per drain), cfg (valid/ready, register index and data; always ready).
// A drain word passes the input registers, the gain lanes and the merge into
// the output queue; mix words produce nothing.
// Throughput: one input word per cycle while in_ready is high, set by the
// 7-stage gain lanes (one per channel) and a single read-modify-write per
// cycle on the accumulation RAM; same-slot words back to back are forwarded
// around the RAM. Reset: the accumulation RAM is cleared one slot per cycle
// with in_ready low; cfg writes are taken throughout.
// Receiver stall: drain results wait in an OUT_DEPTH-word queue; in_ready
// drops once drains in flight plus queued reach OUT_DEPTH. Mix words that
// arrive in that time are still taken only while in_ready is high.
`default_nettype none

`include "assert_macros.svh"

module ramped_gain_sample_mixer #(
  parameter int OUT_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgsm_pkg::mix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rgsm_pkg::mix_out_t out_data
);

  import rgsm_pkg::*;

  localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration
  logic        sample_format;
  logic [1:0]  channel_mode;
  logic [15:0] cur_left;
  logic [15:0] cur_right;
  logic [15:0] tgt_left;
  logic [15:0] tgt_right;
  logic [6:0]  ramp_length;
  logic        output_mono;

  // pipeline control
  logic                    accept;
  logic                    drain_accept;
  logic [LANE_STAGES:0]    st_valid;
  logic                    st_op   [LANE_STAGES+1];
  logic [SLOT_W-1:0]       st_slot [LANE_STAGES+1];
  logic [15:0]             s0_pos;
  logic [15:0]             s0_first;
  logic [15:0]             s0_second;

  logic signed [15:0] dec_first;
  logic signed [15:0] dec_second;
  logic signed [16:0] left_sample;
  logic signed [16:0] right_sample;
  logic               spatial;
  logic [6:0]         ramp_len;
  lane_in_t           left_in;
  lane_in_t           right_in;
  logic [31:0]        contrib_left;
  logic [31:0]        contrib_right;

  // accumulation memory
  logic              clearing;
  logic [SLOT_W-1:0] clear_addr;
  logic [63:0]       rd_data;
  acc_ctl_t          merge_ctl;
  ram_wr_t           merge_wr;
  ram_wr_t           ram_wr;

  // output queue
  logic              res_valid;
  mix_out_t          res;
  mix_out_t          fifo_mem [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fifo_count;
  logic [CNT_W-1:0]  pending;
  logic              pop;

  function automatic logic signed [15:0] decode_sample(input logic fmt,
                                                      input logic [15:0] raw);
    logic signed [8:0]  centered;
    logic signed [16:0] scaled;
    centered = $signed({1'b0, raw[7:0]}) - 9'sd128;
    scaled   = (17'(centered) <<< 8) - 17'(centered);
    if (fmt == FMT_U8) begin
      return scaled[15:0];
    end
    return raw;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_S16;
      channel_mode  <= MODE_MONO;
      cur_left      <= 16'd0;
      cur_right     <= 16'd0;
      tgt_left      <= 16'd0;
      tgt_right     <= 16'd0;
      ramp_length   <= 7'd0;
      output_mono   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_FORMAT: sample_format <= cfg_data[0];
        REG_CHANNEL_MODE:  channel_mode  <= cfg_data[1:0];
        REG_CUR_LEFT:      cur_left      <= cfg_data;
        REG_CUR_RIGHT:     cur_right     <= cfg_data;
        REG_TGT_LEFT:      tgt_left      <= cfg_data;
        REG_TGT_RIGHT:     tgt_right     <= cfg_data;
        REG_RAMP_LENGTH:   ramp_length   <= cfg_data[6:0];
        REG_OUTPUT_MONO:   output_mono   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready     = !clearing && (pending < CNT_W'(OUT_DEPTH));
  assign accept       = in_valid && in_ready;
  assign drain_accept = accept && (in_data.operation == OP_DRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      st_valid <= {st_valid[LANE_STAGES-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_op[0]   <= in_data.operation;
      st_slot[0] <= in_data.buffer_slot;
      s0_pos     <= in_data.run_position;
      s0_first   <= in_data.sample_first;
      s0_second  <= in_data.sample_second;
    end
    for (int i = 1; i <= LANE_STAGES; i++) begin
      st_op[i]   <= st_op[i-1];
      st_slot[i] <= st_slot[i-1];
    end
  end

  assign dec_first  = decode_sample(sample_format, s0_first);
  assign dec_second = decode_sample(sample_format, s0_second);
  assign ramp_len   = (ramp_length > RAMP_MAX) ? RAMP_MAX : ramp_length;

  always_comb begin
    case (channel_mode)
      MODE_MONO: begin
        left_sample  = 17'(dec_first);
        right_sample = 17'(dec_first);
        spatial      = 1'b0;
      end
      MODE_STEREO: begin
        left_sample  = 17'(dec_first);
        right_sample = 17'(dec_second);
        spatial      = 1'b0;
      end
      default: begin
        // spatialized stereo, spare code included
        left_sample  = 17'(dec_first) + 17'(dec_second);
        right_sample = 17'(dec_first) + 17'(dec_second);
        spatial      = 1'b1;
      end
    endcase
  end

  always_comb begin
    left_in.sample      = left_sample;
    left_in.cur_volume  = cur_left;
    left_in.tgt_volume  = tgt_left;
    left_in.position    = s0_pos;
    left_in.ramp_len    = ramp_len;
    left_in.spatial     = spatial;
    right_in.sample     = right_sample;
    right_in.cur_volume = cur_right;
    right_in.tgt_volume = tgt_right;
    right_in.position   = s0_pos;
    right_in.ramp_len   = ramp_len;
    right_in.spatial    = spatial;
  end

  rgsm_lane u_lane_left (
    .clk     (clk),
    .lane_in (left_in),
    .contrib (contrib_left)
  );

  rgsm_lane u_lane_right (
    .clk     (clk),
    .lane_in (right_in),
    .contrib (contrib_right)
  );

  // sweep zeros through the memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == SLOT_W'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    merge_ctl.valid = st_valid[LANE_STAGES];
    merge_ctl.op    = st_op[LANE_STAGES];
    merge_ctl.slot  = st_slot[LANE_STAGES];
    if (clearing) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clear_addr;
      ram_wr.data = 64'd0;
    end else begin
      ram_wr = merge_wr;
    end
  end

  // read one stage early so the word lines up with the lane results
  rgsm_ram #(
    .WIDTH (64),
    .DEPTH (SLOTS)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (st_slot[LANE_STAGES-1]),
    .rd_data (rd_data)
  );

  rgsm_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (merge_ctl),
    .contrib_left  (contrib_left),
    .contrib_right (contrib_right),
    .rd_data       (rd_data),
    .output_mono   (output_mono),
    .wr            (merge_wr),
    .res_valid     (res_valid),
    .res           (res)
  );

  assign out_valid = (fifo_count != '0);
  assign out_data  = fifo_mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      pending    <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + CNT_W'(res_valid) - CNT_W'(pop);
      // reserve a queue word for every drain in flight
      pending    <= pending + CNT_W'(drain_accept) - CNT_W'(pop);
    end
  end

  `ASSERT_ALWAYS(a_queue_reserved, clk, rst, pending >= fifo_count, "queue word not reserved")
  `ASSERT_ALWAYS(a_idle_while_clearing, clk, rst, !clearing || (st_valid == '0), "busy in clear")
  `ASSERT_IMPLY(a_drain_result, clk, rst, drain_accept, ##(LANE_STAGES + 1) res_valid, "drain lost")

endmodule

`default_nettype wire

/* tb/sv/tb_ramped_gain_sample_mixer.sv */
`default_nettype none

module tb_ramped_gain_sample_mixer;
  import rgsm_pkg::*;

  localparam logic [1:0] MODE_SPATIAL = 2'd2;
  localparam logic [1:0] MODE_SPATIAL_ALT = 2'd3;
  localparam int SETTLE_CYCLES = 4 * LANE_STAGES;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int TIMEOUT_UNITS = 2_000_000;
  localparam int WRAP_SLOT = 900;

  typedef enum logic [1:0] {STEP_REG, STEP_WORD, STEP_FIXED} step_kind_e;

  typedef struct {
    step_kind_e kind;
    logic [2:0] index;
    logic [15:0] data;
    mix_in_t word;
    mix_out_t fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_ready;
  mix_in_t in_data;
  logic out_valid;
  logic out_ready;
  mix_out_t out_data;

  // model copy of the register file and the accumulation memory
  logic cfg_format;
  logic [1:0] cfg_mode;
  logic [15:0] vol_cur_l, vol_cur_r, vol_tgt_l, vol_tgt_r;
  logic [6:0] cfg_ramp;
  logic cfg_mono_out;
  logic [63:0] slot_sums [SLOTS];

  mix_out_t drained_pairs [$];
  stim_row_t directed_rows [$];
  int fail_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int holdoff_asked = 0;
  int holdoff_done = 0;
  int holdoff_left = 0;

  ramped_gain_sample_mixer dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic longint decode_sample(logic [15:0] raw);
    if (cfg_format == FMT_U8) return (longint'(raw[7:0]) - 128) * 255;
    return longint'($signed(raw));
  endfunction

  function automatic logic [31:0] gain_term(longint s, logic [15:0] cur, logic [15:0] tgt,
                                            logic [15:0] pos, longint scale);
    longint r, k, num, g, prod;
    r = (cfg_ramp > RAMP_MAX) ? RAMP_MAX : cfg_ramp;
    if (longint'(pos) < r) begin
      k = longint'(pos) + 1;
      num = (longint'(cur) * (r - k) + longint'(tgt) * k) * 256;
      g = num / (r * scale);
      prod = (s * g) / 256;
    end else begin
      prod = s * (longint'(tgt) / scale);
    end
    return prod[31:0];
  endfunction

  function automatic logic [15:0] drain_level(logic [31:0] acc);
    longint q;
    q = longint'($signed(acc)) / 256;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Apply one word to the model; returns 1 when a drain pair comes out.
  function automatic bit advance_mixer(mix_in_t w, output mix_out_t pair);
    logic [31:0] acc_l, acc_r;
    longint a, b, sl, sr, scale;
    acc_l = slot_sums[w.buffer_slot][31:0];
    acc_r = slot_sums[w.buffer_slot][63:32];
    pair = '0;
    if (w.operation == OP_DRAIN) begin
      pair.out_left = drain_level(acc_l);
      pair.out_right = cfg_mono_out ? 16'sd0 : drain_level(acc_r);
      slot_sums[w.buffer_slot] = '0;
      return 1'b1;
    end
    a = decode_sample(w.sample_first);
    b = decode_sample(w.sample_second);
    scale = 256;
    case (cfg_mode)
      MODE_MONO: begin
        sl = a;
        sr = a;
      end
      MODE_STEREO: begin
        sl = a;
        sr = b;
      end
      default: begin
        sl = a + b;
        sr = a + b;
        scale = 512;
      end
    endcase
    acc_l += gain_term(sl, vol_cur_l, vol_tgt_l, w.run_position, scale);
    acc_r += gain_term(sr, vol_cur_r, vol_tgt_r, w.run_position, scale);
    slot_sums[w.buffer_slot] = {acc_r, acc_l};
    return 1'b0;
  endfunction

  function automatic void add_reg(logic [2:0] idx, logic [15:0] data);
    stim_row_t row;
    row.kind = STEP_REG;
    row.index = idx;
    row.data = data;
    row.word = '0;
    row.fixed = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_word(logic op, int slot, int pos, int a, int b);
    stim_row_t row;
    row.kind = STEP_WORD;
    row.index = '0;
    row.data = '0;
    row.word.operation = op;
    row.word.buffer_slot = SLOT_W'(slot);
    row.word.run_position = 16'(pos);
    row.word.sample_first = 16'(a);
    row.word.sample_second = 16'(b);
    row.fixed = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_fixed_drain(int slot, int left, int right);
    add_word(OP_DRAIN, slot, 0, 0, 0);
    directed_rows[$].kind = STEP_FIXED;
    directed_rows[$].fixed.out_left = 16'(left);
    directed_rows[$].fixed.out_right = 16'(right);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return {8'($urandom), 8'hFF};
      3: return {8'($urandom), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mix_in_t random_word(int drain_pct);
    mix_in_t w;
    w.operation = ($urandom_range(0, 99) < drain_pct) ? OP_DRAIN : OP_MIX;
    if ($urandom_range(0, 3) != 0) w.buffer_slot = SLOT_W'($urandom_range(0, 7));
    else w.buffer_slot = SLOT_W'($urandom_range(0, SLOTS - 1));
    if ($urandom_range(0, 3) == 0) w.run_position = 16'($urandom);
    else w.run_position = 16'($urandom_range(0, 130));
    w.sample_first = pick_sample();
    w.sample_second = pick_sample();
    return w;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SAMPLE_FORMAT: cfg_format = data[0];
      REG_CHANNEL_MODE: cfg_mode = data[1:0];
      REG_CUR_LEFT: vol_cur_l = data;
      REG_CUR_RIGHT: vol_cur_r = data;
      REG_TGT_LEFT: vol_tgt_l = data;
      REG_TGT_RIGHT: vol_tgt_r = data;
      REG_RAMP_LENGTH: cfg_ramp = data[6:0];
      REG_OUTPUT_MONO: cfg_mono_out = data[0];
      default: ;
    endcase
  endtask

  // Every register write is followed by a word, which drops cfg_valid here.
  task automatic send_word(mix_in_t w, bit use_fixed, mix_out_t fixed);
    mix_out_t pair;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (advance_mixer(w, pair)) drained_pairs.push_back(use_fixed ? fixed : pair);
  endtask

  // Hold the input until every drain has come out and the lanes are empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (drained_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_random_settings();
    logic [15:0] val, keep, junk;
    settle();
    for (int i = 0; i < 8; i++) begin
      keep = 16'hFFFF;
      case (3'(i))
        REG_SAMPLE_FORMAT: begin
          val = 16'($urandom_range(0, 1));
          keep = 16'h0001;
        end
        REG_CHANNEL_MODE: begin
          val = 16'($urandom_range(0, 3));
          keep = 16'h0003;
        end
        REG_RAMP_LENGTH: begin
          case ($urandom_range(0, 3))
            0: val = 16'd0;
            1: val = 16'($urandom_range(1, 64));
            2: val = 16'($urandom_range(65, 127));
            default: val = 16'(RAMP_MAX);
          endcase
          keep = 16'h007F;
        end
        REG_OUTPUT_MONO: begin
          val = 16'($urandom_range(0, 1));
          keep = 16'h0001;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: val = 16'h0000;
            1: val = 16'hFFFF;
            2: val = {8'($urandom), 8'h00};
            default: val = 16'($urandom);
          endcase
        end
      endcase
      junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
      write_reg(3'(i), (val & keep) | (junk & ~keep));
    end
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_done != holdoff_asked) begin
      out_ready <= 1'b0;
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= holdoff_done + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    mix_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (drained_pairs.size() == 0) begin
        $error("unexpected output word: out_left %0d out_right %0d",
               out_data.out_left, out_data.out_right);
        fail_count++;
      end else begin
        want = drained_pairs.pop_front();
        if (out_data.out_left !== want.out_left) begin
          $error("out_left: expected %0d, got %0d", want.out_left, out_data.out_left);
          fail_count++;
        end
        if (out_data.out_right !== want.out_right) begin
          $error("out_right: expected %0d, got %0d", want.out_right, out_data.out_right);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    mix_in_t w;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_format = FMT_S16;
    cfg_mode = MODE_MONO;
    vol_cur_l = '0;
    vol_cur_r = '0;
    vol_tgt_l = '0;
    vol_tgt_r = '0;
    cfg_ramp = '0;
    cfg_mono_out = 1'b0;
    foreach (slot_sums[i]) slot_sums[i] = '0;

    // drains after reset and at zero volume are all zero
    add_fixed_drain(0, 0, 0);
    add_word(OP_MIX, 5, 0, 32767, -1);
    add_fixed_drain(5, 0, 0);
    // full gain, three full-scale frames saturate both ways
    add_reg(REG_TGT_LEFT, 16'hFFFF);
    add_reg(REG_TGT_RIGHT, 16'hFFFF);
    repeat (3) add_word(OP_MIX, 2, 100, 32767, -32768);
    add_fixed_drain(2, 32767, 32767);
    repeat (3) add_word(OP_MIX, 3, 65535, -32768, 32767);
    add_fixed_drain(3, -32768, -32768);
    // mono output zeroes the right channel
    add_reg(REG_OUTPUT_MONO, 16'd1);
    add_word(OP_MIX, 4, 0, 32767, 0);
    add_fixed_drain(4, 32639, 0);
    add_reg(REG_OUTPUT_MONO, 16'd0);
    add_reg(REG_CHANNEL_MODE, 16'(MODE_STEREO));
    add_reg(REG_TGT_RIGHT, 16'd256);
    add_word(OP_MIX, 6, 7, 1000, -2000);
    add_word(OP_DRAIN, 6, 0, 0, 0);
    // spatialized mode, then the unused fourth mode code
    add_reg(REG_CHANNEL_MODE, 16'(MODE_SPATIAL));
    add_reg(REG_TGT_LEFT, 16'd1536);
    add_reg(REG_TGT_RIGHT, 16'd511);
    add_word(OP_MIX, 7, 0, -32768, -32768);
    add_reg(REG_CHANNEL_MODE, 16'(MODE_SPATIAL_ALT));
    add_word(OP_MIX, 7, 0, 12345, 32767);
    add_word(OP_DRAIN, 7, 0, 0, 0);
    // 8-bit samples: only the low byte counts
    add_reg(REG_CHANNEL_MODE, 16'(MODE_MONO));
    add_reg(REG_SAMPLE_FORMAT, 16'(FMT_U8));
    add_reg(REG_TGT_LEFT, 16'd1024);
    add_reg(REG_TGT_RIGHT, 16'd1024);
    add_word(OP_MIX, 8, 0, 16'hFF00, 16'h1234);
    add_word(OP_MIX, 8, 0, 16'h00FF, 16'hABCD);
    add_word(OP_MIX, 8, 0, 16'h5A80, 16'h0000);
    add_word(OP_DRAIN, 8, 0, 0, 0);
    // gain ramp inside, at the end of and past the ramp; then clamped length
    add_reg(REG_SAMPLE_FORMAT, 16'(FMT_S16));
    add_reg(REG_CHANNEL_MODE, 16'(MODE_STEREO));
    add_reg(REG_CUR_LEFT, 16'd0);
    add_reg(REG_TGT_LEFT, 16'hFFFF);
    add_reg(REG_CUR_RIGHT, 16'hFFFF);
    add_reg(REG_TGT_RIGHT, 16'd0);
    add_reg(REG_RAMP_LENGTH, 16'd4);
    add_word(OP_MIX, 9, 0, 20000, 20000);
    add_word(OP_MIX, 9, 3, 20000, 20000);
    add_word(OP_MIX, 9, 4, 20000, 20000);
    add_word(OP_DRAIN, 9, 0, 0, 0);
    add_reg(REG_RAMP_LENGTH, 16'd127);
    add_word(OP_MIX, 10, 63, -20000, 20000);
    add_word(OP_MIX, 10, 64, -20000, 20000);
    add_word(OP_DRAIN, 10, 0, 0, 0);
    add_fixed_drain(SLOTS - 1, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STEP_REG) begin
        if (i == 0 || directed_rows[i-1].kind != STEP_REG) settle();
        write_reg(directed_rows[i].index, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i].word, directed_rows[i].kind == STEP_FIXED,
                  directed_rows[i].fixed);
      end
    end

    for (int phase = 0; phase < 7; phase++) begin
      pick_random_settings();
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      for (int n = 0; n < 12; n++) begin
        if (phase == 1 && n == 6) settle();
        send_word(random_word(30), 1'b0, '0);
      end
    end

    // drain-heavy burst against a stalled receiver: fill up and back-pressure
    pick_random_settings();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    holdoff_asked++;
    repeat (40) send_word(random_word(85), 1'b0, '0);

    // pile full-scale frames into one slot until both 32-bit sums wrap
    settle();
    write_reg(REG_SAMPLE_FORMAT, 16'(FMT_S16));
    write_reg(REG_CHANNEL_MODE, 16'(MODE_STEREO));
    write_reg(REG_TGT_LEFT, 16'hFFFF);
    write_reg(REG_TGT_RIGHT, 16'hFFFF);
    write_reg(REG_RAMP_LENGTH, 16'd0);
    write_reg(REG_OUTPUT_MONO, 16'd0);
    src_idle_pct = 14;
    sink_stall_pct = 14;
    w = '0;
    w.operation = OP_DRAIN;
    w.buffer_slot = SLOT_W'(WRAP_SLOT);
    send_word(w, 1'b0, '0);
    w.operation = OP_MIX;
    w.run_position = 16'd1000;
    w.sample_first = 16'h7FFF;
    w.sample_second = 16'h8000;
    repeat (260) send_word(w, 1'b0, '0);
    w.operation = OP_DRAIN;
    send_word(w, 1'b0, '0);

    settle();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
